// ----- hdl/gfr_pkg.sv -----
// shared types, constants and helpers for the gaussian fit residual block
package gfr_pkg;

   // fixed-point format
   localparam int FRAC_BITS = 16;

   // interface widths
   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 224;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W = 32;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_BASELINE = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_HEIGHT   = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_CENTER   = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_WIDTH    = 8'd3;

   // exp(-1) in Q2.30 and taylor series length
   localparam logic [32:0] EXP_M1_Q30 = 33'd395007542;
   localparam logic [3:0] TAYLOR_TERMS = 4'd12;
   localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
   localparam logic [32:0] EXP_ROUND = 33'd8192;

   // sequencer states
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_QDIV,
      ST_SQMUL,
      ST_TMUL,
      ST_TDIV,
      ST_EXPMUL,
      ST_AEMUL,
      ST_RESDIV,
      ST_CHIMUL,
      ST_BASEDIV,
      ST_HGTDIV,
      ST_GMUL,
      ST_GDIV,
      ST_CENDIV,
      ST_HMUL,
      ST_HDIV,
      ST_WIDDIV,
      ST_DONE
   } state_type;

   // divider request and response
   typedef struct packed {
      logic              start;
      logic signed [63:0] num;
      logic [31:0]       den;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic signed [63:0] quo;
   } div_rsp_type;

   // multiplier operands
   typedef struct packed {
      logic signed [35:0] a;
      logic signed [32:0] b;
   } mul_req_type;

   // clamp a wide signed value to 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) r = 32'sh7FFF_FFFF;
      else if (v < -64'sd2147483648) r = 32'sh8000_0000;
      else r = v[31:0];
      return r;
   endfunction

   // ceil(2^34 / k) for series index k, exact floor division of terms below 2^30
   function automatic logic [35:0] recip_k(input logic [3:0] k);
      logic [35:0] r;
      case (k)
         4'd1:    r = 36'd17179869184;
         4'd2:    r = 36'd8589934592;
         4'd3:    r = 36'd5726623062;
         4'd4:    r = 36'd4294967296;
         4'd5:    r = 36'd3435973837;
         4'd6:    r = 36'd2863311531;
         4'd7:    r = 36'd2454267027;
         4'd8:    r = 36'd2147483648;
         4'd9:    r = 36'd1908874354;
         4'd10:   r = 36'd1717986919;
         4'd11:   r = 36'd1561806290;
         4'd12:   r = 36'd1431655766;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// ----- hdl/gaussian_fit_residual_jacobian.sv -----
// top level: sequencer around a shared divider and multiplier
// Gaussian model y0 + A*exp(-(x-c)^2/(2w^2)) residual and Jacobian for one data point per
// request, all values Q16.16 with saturation, signed but for sigma and the 63-bit chi-square
// sum. A request is taken only while the sequencer is idle; its result is loaded into an
// output register when it is finished, so the next request may enter while that result
// waits. The time of a point is set by the one-bit-a-cycle divider, which runs eight
// fixed-point divisions, and by 29 products (the series divides each term by its index
// through a reciprocal product) plus one product by exp(-1) per unit of the integer part of
// the exponent (up to 31). A point with |x-c|/|w| of 8 or more skips the exponential and
// the last four divisions. A zero width or sigma goes straight from idle to the last state
// with math_error set and zero results. A result held by the receiver stalls the sequencer
// in its last state. The chi-square sum includes the current point and is cleared after a
// point with tlast set.
module gaussian_fit_residual_jacobian (
   input  logic                               clock,
   input  logic                               reset,
   // x_value, y_value, sigma_value
   input  logic [gfr_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                               req_tlast,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // residual, chi_square, jac_baseline, jac_height, jac_center, jac_width, zero pad
   output logic [gfr_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // math_error
   output logic                               rsp_tuser,
   output logic                               rsp_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic                               csr_we,
   input  logic [gfr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [gfr_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import gfr_pkg::*;

   state_type state_ff, state_in;
   logic phase_ff, phase_in;

   logic signed [31:0] y0_ff, y0_in, amp_ff, amp_in, cen0_ff, cen0_in, w_ff, w_in;
   logic signed [31:0] y_ff, y_in;
   logic [31:0] sig_ff, sig_in;
   logic last_ff, last_in;
   logic err_ff, err_in;
   logic signed [32:0] d_ff, d_in;
   logic signed [50:0] q_ff, q_in;
   logic [4:0] ip_ff, ip_in;
   logic [29:0] f30_ff, f30_in;
   logic [30:0] term_ff, term_in;
   logic signed [31:0] sum_ff, sum_in;
   logic [3:0] k_ff, k_in;
   logic [30:0] v_ff, v_in;
   logic [16:0] e_ff, e_in;
   logic signed [32:0] ae_ff, ae_in;
   logic signed [31:0] r_ff, r_in;
   logic signed [35:0] g_ff, g_in;
   logic signed [63:0] tmp_ff, tmp_in;
   logic signed [31:0] base_ff, base_in, hgt_ff, hgt_in, jc_ff, jc_in, jw_ff, jw_in;
   logic [62:0] acc_ff, acc_in;
   logic [62:0] chi_ff, chi_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic rsp_user_ff, rsp_user_in;
   logic rsp_last_ff, rsp_last_in;

   div_req_type div_req;
   div_rsp_type div_rsp;
   mul_req_type mul_req;
   logic signed [68:0] mul_prod;

   logic [31:0] wa;
   logic accept;
   logic [63:0] chi_sum;
   logic [32:0] e_round;
   logic [30:0] term_q;
   logic signed [31:0] sum_next;

   gfr_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   gfr_mul u_mul (
      .clock    (clock),
      .mul_req  (mul_req),
      .mul_prod (mul_prod)
   );

   assign wa = w_ff[31] ? (~w_ff + 32'd1) : w_ff;
   assign accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);

   // sequencer and datapath next state
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      y0_in = y0_ff; amp_in = amp_ff; cen0_in = cen0_ff; w_in = w_ff;
      y_in = y_ff; sig_in = sig_ff; last_in = last_ff; err_in = err_ff;
      d_in = d_ff; q_in = q_ff; ip_in = ip_ff; f30_in = f30_ff;
      term_in = term_ff; sum_in = sum_ff; k_in = k_ff; v_in = v_ff; e_in = e_ff;
      ae_in = ae_ff; r_in = r_ff; g_in = g_ff; tmp_in = tmp_ff;
      base_in = base_ff; hgt_in = hgt_ff; jc_in = jc_ff; jw_in = jw_ff;
      acc_in = acc_ff; chi_in = chi_ff;
      rsp_valid_in = rsp_valid_ff; rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff; rsp_last_in = rsp_last_ff;
      div_req.start = 1'b0;
      div_req.num = '0;
      div_req.den = sig_ff;
      mul_req.a = '0;
      mul_req.b = '0;
      chi_sum = {1'b0, acc_ff};
      e_round = 33'(v_ff) + EXP_ROUND;
      // series term over its index and the updated partial sum
      term_q = 31'(mul_prod[63:34]);
      sum_next = k_ff[0] ? (sum_ff - $signed(32'(term_q))) : (sum_ff + $signed(32'(term_q)));

      // register writes
      if (csr_we) begin
         unique case (csr_index)
            REG_BASELINE: y0_in = csr_wdata;
            REG_HEIGHT:   amp_in = csr_wdata;
            REG_CENTER:   cen0_in = csr_wdata;
            REG_WIDTH:    w_in = csr_wdata;
            default: ;
         endcase
      end

      // output register drains
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            phase_in = 1'b0;
            if (accept) begin
               y_in = req_tdata[63:32];
               sig_in = req_tdata[95:64];
               last_in = req_tlast;
               d_in = 33'($signed(req_tdata[31:0])) - 33'(cen0_ff);
               r_in = '0; base_in = '0; hgt_in = '0; jc_in = '0; jw_in = '0;
               chi_in = '0;
               if (w_ff == '0 || req_tdata[95:64] == '0) begin
                  err_in = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  err_in = 1'b0;
                  state_in = ST_QDIV;
               end
            end
         end
         ST_QDIV: begin
            div_req.num = 64'(d_ff);
            div_req.den = wa;
            if (!phase_ff) begin
               div_req.start = 1'b1;
               phase_in = 1'b1;
            end else if (div_rsp.done) begin
               phase_in = 1'b0;
               q_in = div_rsp.quo[50:0];
               if (div_rsp.quo >= 64'sd524288 || div_rsp.quo <= -64'sd524288) begin
                  e_in = '0;
                  state_in = ST_AEMUL;
               end else begin
                  state_in = ST_SQMUL;
               end
            end
         end
         ST_SQMUL: begin
            mul_req.a = 36'(q_ff);
            mul_req.b = 33'(q_ff);
            if (!phase_ff) phase_in = 1'b1;
            else begin
               // u = q^2 / 2^17, split into integer and fraction
               phase_in = 1'b0;
               ip_in = mul_prod[37:33];
               f30_in = {mul_prod[32:17], 14'b0};
               term_in = ONE_Q30;
               sum_in = 32'(ONE_Q30);
               k_in = 4'd1;
               state_in = ST_TMUL;
            end
         end
         ST_TMUL: begin
            mul_req.a = 36'(term_ff);
            mul_req.b = 33'(f30_ff);
            if (!phase_ff) phase_in = 1'b1;
            else begin
               phase_in = 1'b0;
               term_in = mul_prod[60:30];
               state_in = ST_TDIV;
            end
         end
         ST_TDIV: begin
            // term / k as a product with ceil(2^34 / k), term below 2^30
            mul_req.a = recip_k(k_ff);
            mul_req.b = 33'(term_ff);
            if (!phase_ff) phase_in = 1'b1;
            else begin
               phase_in = 1'b0;
               term_in = term_q;
               sum_in = sum_next;
               if (k_ff == TAYLOR_TERMS) begin
                  v_in = sum_next[31] ? '0 : sum_next[30:0];
                  state_in = ST_EXPMUL;
               end else begin
                  k_in = k_ff + 4'd1;
                  state_in = ST_TMUL;
               end
            end
         end
         ST_EXPMUL: begin
            // multiply by exp(-1) once per unit of the integer part
            mul_req.a = 36'(v_ff);
            mul_req.b = EXP_M1_Q30;
            if (!phase_ff) begin
               if (ip_ff == '0) begin
                  e_in = e_round[30:14];
                  state_in = ST_AEMUL;
               end else begin
                  phase_in = 1'b1;
               end
            end else begin
               phase_in = 1'b0;
               v_in = mul_prod[60:30];
               ip_in = ip_ff - 5'd1;
            end
         end
         ST_AEMUL: begin
            mul_req.a = 36'(amp_ff);
            mul_req.b = 33'(e_ff);
            if (!phase_ff) phase_in = 1'b1;
            else begin
               phase_in = 1'b0;
               ae_in = mul_prod[48:16];
               state_in = ST_RESDIV;
            end
         end
         ST_RESDIV: begin
            div_req.num = 64'(y0_ff) + 64'(ae_ff) - 64'(y_ff);
            if (!phase_ff) begin
               div_req.start = 1'b1;
               phase_in = 1'b1;
            end else if (div_rsp.done) begin
               phase_in = 1'b0;
               r_in = sat32(div_rsp.quo);
               state_in = ST_CHIMUL;
            end
         end
         ST_CHIMUL: begin
            mul_req.a = 36'(r_ff);
            mul_req.b = 33'(r_ff);
            chi_sum = {1'b0, acc_ff} + 64'(mul_prod[62:16]);
            if (!phase_ff) phase_in = 1'b1;
            else begin
               phase_in = 1'b0;
               acc_in = chi_sum[63] ? '1 : chi_sum[62:0];
               chi_in = chi_sum[63] ? '1 : chi_sum[62:0];
               state_in = ST_BASEDIV;
            end
         end
         ST_BASEDIV: begin
            div_req.num = 64'sd65536;
            if (!phase_ff) begin
               div_req.start = 1'b1;
               phase_in = 1'b1;
            end else if (div_rsp.done) begin
               phase_in = 1'b0;
               base_in = sat32(div_rsp.quo);
               state_in = ST_HGTDIV;
            end
         end
         ST_HGTDIV: begin
            div_req.num = 64'(e_ff);
            if (!phase_ff) begin
               div_req.start = 1'b1;
               phase_in = 1'b1;
            end else if (div_rsp.done) begin
               phase_in = 1'b0;
               hgt_in = sat32(div_rsp.quo);
               state_in = (e_ff == '0) ? ST_DONE : ST_GMUL;
            end
         end
         ST_GMUL: begin
            mul_req.a = 36'(ae_ff);
            mul_req.b = 33'(q_ff);
            if (!phase_ff) phase_in = 1'b1;
            else begin
               phase_in = 1'b0;
               g_in = mul_prod[51:16];
               state_in = ST_GDIV;
            end
         end
         ST_GDIV: begin
            div_req.num = 64'(g_ff);
            div_req.den = wa;
            if (!phase_ff) begin
               div_req.start = 1'b1;
               phase_in = 1'b1;
            end else if (div_rsp.done) begin
               phase_in = 1'b0;
               tmp_in = div_rsp.quo;
               state_in = ST_CENDIV;
            end
         end
         ST_CENDIV: begin
            div_req.num = tmp_ff;
            if (!phase_ff) begin
               div_req.start = 1'b1;
               phase_in = 1'b1;
            end else if (div_rsp.done) begin
               phase_in = 1'b0;
               jc_in = sat32(div_rsp.quo);
               state_in = ST_HMUL;
            end
         end
         ST_HMUL: begin
            mul_req.a = g_ff;
            mul_req.b = 33'(q_ff);
            if (!phase_ff) phase_in = 1'b1;
            else begin
               phase_in = 1'b0;
               tmp_in = 64'($signed(mul_prod[54:16]));
               state_in = ST_HDIV;
            end
         end
         ST_HDIV: begin
            div_req.num = tmp_ff;
            div_req.den = wa;
            if (!phase_ff) begin
               div_req.start = 1'b1;
               phase_in = 1'b1;
            end else if (div_rsp.done) begin
               // flip sign for a negative width
               phase_in = 1'b0;
               tmp_in = w_ff[31] ? -div_rsp.quo : div_rsp.quo;
               state_in = ST_WIDDIV;
            end
         end
         ST_WIDDIV: begin
            div_req.num = tmp_ff;
            if (!phase_ff) begin
               div_req.start = 1'b1;
               phase_in = 1'b1;
            end else if (div_rsp.done) begin
               phase_in = 1'b0;
               jw_in = sat32(div_rsp.quo);
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {1'b0, jw_ff, jc_ff, hgt_ff, base_ff, chi_ff, r_ff};
               rsp_user_in = err_ff;
               rsp_last_in = last_ff;
               if (last_ff) acc_in = '0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= 1'b0;
         y0_ff <= '0;
         amp_ff <= 32'sd65536;
         cen0_ff <= '0;
         w_ff <= 32'sd65536;
         acc_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         y0_ff <= y0_in;
         amp_ff <= amp_in;
         cen0_ff <= cen0_in;
         w_ff <= w_in;
         acc_ff <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      y_ff <= y_in; sig_ff <= sig_in; last_ff <= last_in; err_ff <= err_in;
      d_ff <= d_in; q_ff <= q_in; ip_ff <= ip_in; f30_ff <= f30_in;
      term_ff <= term_in; sum_ff <= sum_in; k_ff <= k_in; v_ff <= v_in; e_ff <= e_in;
      ae_ff <= ae_in; r_ff <= r_in; g_ff <= g_in; tmp_ff <= tmp_in;
      base_ff <= base_in; hgt_ff <= hgt_in; jc_ff <= jc_in; jw_ff <= jw_in;
      chi_ff <= chi_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;
   assign rsp_tlast = rsp_last_ff;

endmodule

// ----- hdl/gfr_mul.sv -----
// registered signed multiplier shared by all product steps
module gfr_mul (
   input  logic                  clock,
   input  gfr_pkg::mul_req_type  mul_req,
   output logic signed [68:0]    mul_prod
);
   import gfr_pkg::*;

   logic signed [68:0] prod_ff;
   logic signed [68:0] prod_in;

   // product of the current operands
   always_comb begin
      prod_in = 69'(mul_req.a) * 69'(mul_req.b);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign mul_prod = prod_ff;

endmodule

// ----- hdl/gfr_div.sv -----
// radix-2 restoring divider for fixed-point quotients, one bit a cycle
module gfr_div (
   input  logic                  clock,
   input  logic                  reset,
   input  gfr_pkg::div_req_type  div_req,
   output gfr_pkg::div_rsp_type  div_rsp
);
   import gfr_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        neg_ff, neg_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic [61:0] bits_ff, bits_in;
   logic [61:0] quo_ff, quo_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] mag;
   logic [79:0] num_ext;
   logic [32:0] shifted;
   logic [32:0] trial;

   // load, overflow check and one quotient bit per cycle
   always_comb begin
      mag = div_req.num[63] ? 64'(-div_req.num) : 64'(div_req.num);
      num_ext = {mag, 16'b0};
      shifted = {rem_ff, bits_ff[61]};
      trial = shifted - {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in = neg_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      bits_in = bits_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      if (div_req.start) begin
         neg_in = div_req.num[63];
         den_in = div_req.den;
         quo_in = '0;
         if ({14'b0, num_ext[79:62]} >= div_req.den) begin
            // quotient at or above the clamp limit
            quo_in = '1;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            rem_in = {14'b0, num_ext[79:62]};
            bits_in = num_ext[61:0];
            cnt_in = 6'd62;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         bits_in = {bits_ff[60:0], 1'b0};
         if (!trial[32]) begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[60:0], 1'b1};
         end else begin
            rem_in = shifted[31:0];
            quo_in = {quo_ff[60:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      bits_ff <= bits_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quo = neg_ff ? -$signed({2'b0, quo_ff}) : $signed({2'b0, quo_ff});

endmodule
